/* rtl/sita_pkg.sv */
// Shared types, constants and decimal tables for the integer to ASCII converter.
`default_nettype none
package sita_pkg;

  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 7;
  localparam int EXP_W   = 4;
  localparam int DIGIT_W = 4;
  localparam int MAX_EXP = 9;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int THR_W   = VALUE_W + 2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;

  typedef struct packed {
    logic               negative;
    logic [EXP_W-1:0]   top_exp;
    logic [VALUE_W-1:0] mag;
  } sita_entry_t;

  function automatic logic [VALUE_W-1:0] pow10(input logic [EXP_W-1:0] k);
    logic [VALUE_W-1:0] r;
    unique case (k)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      4'd9:    r = 32'd1000000000;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/sita_front.sv */
// Front stage: takes an item, splits sign and magnitude, finds the leading digit position.
`default_nettype none
module sita_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [sita_pkg::VALUE_W-1:0] value,
  input  wire logic                         full,
  output logic                              busy,
  output logic                              push,
  output sita_pkg::sita_entry_t             entry
);

  logic                           fvalid;
  logic                           fvalid_next;
  logic                           negative;
  logic [sita_pkg::VALUE_W-1:0]   mag;
  logic [sita_pkg::EXP_W-1:0]     top_exp;
  logic                           accept;

  assign busy   = fvalid && full;
  assign accept = start && !busy;
  assign push   = fvalid && !full;
  assign fvalid_next = accept || (fvalid && !push);

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else begin
      fvalid <= fvalid_next;
    end
    if (accept) begin
      negative <= value[sita_pkg::VALUE_W-1];
      mag      <= value[sita_pkg::VALUE_W-1] ? (sita_pkg::VALUE_W'(0) - value) : value;
    end
  end

  // index of the most significant digit: count of powers 10^1 to 10^9 not above mag
  always_comb begin
    top_exp = '0;
    for (int j = 1; j <= sita_pkg::MAX_EXP; j++) begin
      if (mag >= sita_pkg::pow10(sita_pkg::EXP_W'(j))) begin
        top_exp = top_exp + sita_pkg::EXP_W'(1);
      end
    end
  end

  assign entry.negative = negative;
  assign entry.top_exp  = top_exp;
  assign entry.mag      = mag;

  a_accept_holds: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> fvalid)
    else $error("accepted item not held in front stage");

endmodule
`default_nettype wire

/* rtl/sita_queue.sv */
// Small register queue between front and back stages.
`default_nettype none
module sita_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire sita_pkg::sita_entry_t entry_in,
  input  wire logic                  pop,
  output sita_pkg::sita_entry_t      entry_out,
  output logic                       full,
  output logic                       empty
);

  sita_pkg::sita_entry_t            mem [sita_pkg::QDEPTH];
  logic [sita_pkg::QPTR_W-1:0]      wptr;
  logic [sita_pkg::QPTR_W-1:0]      rptr;
  logic [sita_pkg::QCNT_W-1:0]      count;

  localparam logic [sita_pkg::QPTR_W-1:0] LAST_PTR = sita_pkg::QPTR_W'(sita_pkg::QDEPTH - 1);

  assign full      = (count == sita_pkg::QCNT_W'(sita_pkg::QDEPTH));
  assign empty     = (count == '0);
  assign entry_out = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + sita_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + sita_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + sita_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - sita_pkg::QCNT_W'(1);
      end
    end
    if (push) begin
      mem[wptr] <= entry_in;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

/* rtl/sita_back.sv */
// Back stage: emits the sign and the decimal digits of one item, one character a cycle.
`default_nettype none
module sita_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       empty,
  input  wire sita_pkg::sita_entry_t      entry,
  output logic                            pop,
  output logic                            strobe,
  output logic [sita_pkg::CHAR_W-1:0]     char_code,
  output logic                            last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t                          state;
  logic [sita_pkg::VALUE_W-1:0]    mag;
  logic [sita_pkg::EXP_W-1:0]      exp;
  logic [sita_pkg::THR_W-1:0]      thr [10];
  logic [sita_pkg::DIGIT_W-1:0]    digit;
  logic [sita_pkg::VALUE_W-1:0]    sub;
  logic                            finishing;

  // thr[j] = j * 10^exp; the digit is the largest j with thr[j] not above mag, else 0
  always_comb begin
    thr[0] = '0;
    digit  = '0;
    for (int j = 1; j <= 9; j++) begin
      thr[j] = sita_pkg::THR_W'(j) * sita_pkg::THR_W'(sita_pkg::pow10(exp));
      if ({2'b00, mag} >= thr[j]) begin
        digit = sita_pkg::DIGIT_W'(j);
      end
    end
    sub = thr[digit][sita_pkg::VALUE_W-1:0];
  end

  assign finishing = (state == ST_DIGIT) && (exp == '0);
  assign pop = !empty && ((state == ST_IDLE) || finishing);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            state <= entry.negative ? ST_SIGN : ST_DIGIT;
          end
        end
        ST_SIGN: begin
          strobe <= 1'b1;
          state  <= ST_DIGIT;
        end
        ST_DIGIT: begin
          strobe <= 1'b1;
          if (finishing) begin
            if (!empty) begin
              state <= entry.negative ? ST_SIGN : ST_DIGIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
    if (pop) begin
      mag <= entry.mag;
      exp <= entry.top_exp;
    end else if (state == ST_DIGIT) begin
      mag <= mag - sub;
      exp <= exp - sita_pkg::EXP_W'(1);
    end
    if (state == ST_SIGN) begin
      char_code <= sita_pkg::CHAR_MINUS;
      last      <= 1'b0;
    end else begin
      char_code <= sita_pkg::CHAR_ZERO + sita_pkg::CHAR_W'(digit);
      last      <= finishing;
    end
  end

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((char_code == sita_pkg::CHAR_MINUS) ||
                ((char_code >= sita_pkg::CHAR_ZERO) && (char_code <= sita_pkg::CHAR_NINE))))
    else $error("character out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (char_code == sita_pkg::CHAR_MINUS)) |-> !last)
    else $error("minus sign flagged as last");

  a_minus_then_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIGN) |=> (state == ST_DIGIT))
    else $error("sign not followed by digits");

endmodule
`default_nettype wire

/* rtl/signed_int_to_decimal_ascii_top.sv */
// Top level of the signed 32-bit integer to decimal ASCII converter.
//
//   channel   signals                      handshake
//   input     value[31:0] (signed)         start, busy; taken when start && !busy
//   result    char_code[6:0], last         strobe; one cycle, cannot be held off
//
// Each item yields 1 to 11 characters, one per cycle from the digit unit in the
// back stage; an item occupies that unit until its last character is out.
// The first character follows the front register, the queue and the back state.
// A two-entry queue sits between front and back; busy rises when it is full
// and the front stage holds an item.
// rst is synchronous and clears the control state; no item survives reset.
`default_nettype none
module signed_int_to_decimal_ascii_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [sita_pkg::VALUE_W-1:0] value,
  output logic                                     strobe,
  output logic [sita_pkg::CHAR_W-1:0]              char_code,
  output logic                                     last
);

  sita_pkg::sita_entry_t q_in;
  sita_pkg::sita_entry_t q_out;
  logic                  push;
  logic                  pop;
  logic                  full;
  logic                  empty;

  sita_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (value),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .entry (q_in)
  );

  sita_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (q_in),
    .pop       (pop),
    .entry_out (q_out),
    .full      (full),
    .empty     (empty)
  );

  sita_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .entry     (q_out),
    .pop       (pop),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
  );

endmodule
`default_nettype wire
